// ===== rtl/core/dld_pkg.sv =====
// ============================================================================
// dld_pkg
// Shared sizes, codes, channel structs and value helpers for the deque.
// ============================================================================
package dld_pkg;

    localparam int CAPACITY    = 32;
    localparam int VALUE_WIDTH = 32;
    localparam int SLOT_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int COUNT_W     = $clog2(CAPACITY + 1);

    typedef logic [SLOT_W-1:0]      t_slot;
    typedef logic [COUNT_W-1:0]     t_count;
    typedef logic [VALUE_WIDTH-1:0] t_val;

    typedef enum logic [2:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_INSERT     = 3'd4,
        OP_DUMP       = 3'd5
    } t_op;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_INVALID = 3'd2,
        ST_OOB     = 3'd3,
        ST_FULL    = 3'd4
    } t_status;

    typedef struct packed {
        t_slot next;
        t_slot prev;
    } t_link;

    // Request from the sequencer to the node store.
    typedef struct packed {
        logic  rd_en;
        t_slot rd_addr;
        logic  we_next;
        logic  we_prev;
        logic  we_val;
        t_slot wr_addr;
        t_slot wr_next;
        t_slot wr_prev;
        t_val  wr_val;
    } t_mem_req;

    // Read data, in the cycle after the request.
    typedef struct packed {
        t_slot next;
        t_slot prev;
        t_val  value;
    } t_mem_rsp;

    // One result toward the output register.
    typedef struct packed {
        logic        valid;
        t_status     status;
        logic [31:0] data;
        logic [5:0]  length;
        logic        last;
    } t_emit;

    function automatic t_slot slot_inc(input t_slot s);
        t_slot r;
        if (s == SLOT_W'(CAPACITY - 1)) begin
            r = '0;
        end else begin
            r = s + 1'b1;
        end
        return r;
    endfunction

    function automatic t_val to_store(input logic [31:0] v);
        logic signed [31:0] sv;
        logic signed [63:0] wide;
        sv   = v;
        wide = 64'(sv);
        return wide[VALUE_WIDTH-1:0];
    endfunction

    function automatic logic [31:0] from_store(input t_val v);
        logic signed [VALUE_WIDTH-1:0] sv;
        logic signed [63:0]            wide;
        sv   = v;
        wide = 64'(sv);
        return wide[31:0];
    endfunction

endpackage

// ===== rtl/core/doubly_linked_list_deque.sv =====
// ============================================================================
// doubly_linked_list_deque
// Bounded deque of signed values held as a doubly linked list in a node pool.
// ============================================================================
// One request is processed at a time; the block takes it on i_in_valid and
// o_in_ready, and o_in_ready stays low until its last result is placed in
// the output register. A refused or trivial request (full, empty, bad
// position, unused code) passes through S_REPLY, a pop through S_POP, a push
// or an insert at either end through S_LINK1 and S_LINK2; an insert inside
// the list walks from the head, one read per position, then relinks through
// S_LINK1, S_LINK3 and S_LINK2. A dump gives one result per cycle while the
// output register is free. Each link hop in a walk or a dump is one read on
// the single, registered read port of the node store, and a relink takes
// one write per touched node. The pool needs no clearing pass after reset;
// the free chain is built from per-slot flags.
// A result waits in the output register while the next request is taken.
module doubly_linked_list_deque (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_operation,
    input  logic signed [31:0] i_value,
    input  logic signed [6:0]  i_position,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [2:0]         o_status,
    output logic signed [31:0] o_data_out,
    output logic [5:0]         o_length,
    output logic               o_last
);
    import dld_pkg::*;

    t_mem_req    mem_req;
    t_mem_rsp    mem_rsp;
    t_emit       emit;
    logic        out_free;

    logic        r_out_valid;
    t_status     r_out_status;
    logic [31:0] r_out_data;
    logic [5:0]  r_out_length;
    logic        r_out_last;

    // The output register is free when empty or when its result leaves now.
    assign out_free = !r_out_valid || i_out_ready;

    // Sequencer: decode, walk, relink, count.
    dld_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_operation),
        .i_value     (i_value),
        .i_position  (i_position),
        .i_out_free  (out_free),
        .o_mem_req   (mem_req),
        .i_mem_rsp   (mem_rsp),
        .o_emit      (emit)
    );

    // Node pool: links and values.
    dld_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rsp   (mem_rsp)
    );

    // Output register: load a new result, otherwise drop the taken one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (emit.valid) begin
            r_out_status <= emit.status;
            r_out_data   <= emit.data;
            r_out_length <= emit.length;
            r_out_last   <= emit.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_data_out  = r_out_data;
    assign o_length    = r_out_length;
    assign o_last      = r_out_last;

endmodule

// ===== rtl/core/dld_store.sv =====
// ============================================================================
// dld_store
// Node store: link memory (next, prev) and value memory, one write and one
// registered read per cycle. Free-chain links read as the successor slot
// until first written.
// ============================================================================
module dld_store (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dld_pkg::t_mem_req i_req,
    output dld_pkg::t_mem_rsp o_rsp
);
    import dld_pkg::*;

    t_link                 r_link_mem [CAPACITY];
    t_val                  r_val_mem  [CAPACITY];
    logic [CAPACITY-1:0]   r_nvalid;

    t_link                 r_rd_link;
    t_val                  r_rd_val;
    logic                  r_rd_valid;
    t_slot                 r_rd_addr;

    always_ff @(posedge i_clk) begin
        if (i_req.we_next) begin
            r_link_mem[i_req.wr_addr].next <= i_req.wr_next;
        end
        if (i_req.we_prev) begin
            r_link_mem[i_req.wr_addr].prev <= i_req.wr_prev;
        end
        if (i_req.we_val) begin
            r_val_mem[i_req.wr_addr] <= i_req.wr_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_link  <= r_link_mem[i_req.rd_addr];
            r_rd_val   <= r_val_mem[i_req.rd_addr];
            r_rd_valid <= r_nvalid[i_req.rd_addr];
            r_rd_addr  <= i_req.rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nvalid <= '0;
        end else if (i_req.we_next) begin
            r_nvalid[i_req.wr_addr] <= 1'b1;
        end
    end

    always_comb begin
        o_rsp.next  = r_rd_valid ? r_rd_link.next : slot_inc(r_rd_addr);
        o_rsp.prev  = r_rd_link.prev;
        o_rsp.value = r_rd_val;
    end

endmodule

// ===== rtl/core/dld_ctrl.sv =====
// ============================================================================
// dld_ctrl
// Operation sequencer: decodes a request, walks and relinks nodes through
// the store, keeps head, tail, free head and count, and issues results.
// ============================================================================
module dld_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_operation,
    input  logic signed [31:0] i_value,
    input  logic signed [6:0]  i_position,
    input  logic               i_out_free,
    output dld_pkg::t_mem_req  o_mem_req,
    input  dld_pkg::t_mem_rsp  i_mem_rsp,
    output dld_pkg::t_emit     o_emit
);
    import dld_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_REPLY,
        S_WALK,
        S_LINK1,
        S_LINK2,
        S_LINK3,
        S_POP,
        S_DUMP
    } t_state;

    typedef enum logic [1:0] {
        INS_BACK,
        INS_FRONT,
        INS_MID
    } t_ins;

    t_state  r_state,  n_state;
    t_ins    r_kind,   n_kind;
    logic    r_front,  n_front;
    t_status r_status, n_status;
    t_val    r_value,  n_value;
    t_slot   r_head,   n_head;
    t_slot   r_tail,   n_tail;
    t_slot   r_free,   n_free;
    t_slot   r_cur,    n_cur;
    t_slot   r_nx,     n_nx;
    t_slot   r_new,    n_new;
    t_count  r_count,  n_count;
    t_count  r_left,   n_left;

    logic    full;
    logic    pos_neg;
    logic    pos_gt;
    logic    pos_zero;
    logic    pos_end;
    t_slot   pop_slot;

    always_comb begin
        full     = (r_count == COUNT_W'(CAPACITY));
        pos_neg  = i_position[6];
        pos_gt   = 8'(i_position[5:0]) > 8'(r_count);
        pos_zero = (i_position[5:0] == 6'd0);
        pos_end  = 8'(i_position[5:0]) == 8'(r_count);
        pop_slot = r_front ? r_head : r_tail;
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_kind    = r_kind;
        n_front   = r_front;
        n_status  = r_status;
        n_value   = r_value;
        n_head    = r_head;
        n_tail    = r_tail;
        n_free    = r_free;
        n_cur     = r_cur;
        n_nx      = r_nx;
        n_new     = r_new;
        n_count   = r_count;
        n_left    = r_left;
        o_mem_req = '0;
        o_emit    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_value  = to_store(i_value);
                    n_status = ST_OK;
                    n_state  = S_REPLY;
                    unique case (t_op'(i_operation))
                        OP_PUSH_BACK, OP_PUSH_FRONT: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_kind            = (t_op'(i_operation) == OP_PUSH_BACK) ?
                                                    INS_BACK : INS_FRONT;
                                o_mem_req.rd_en   = 1'b1;
                                o_mem_req.rd_addr = r_free;
                                n_state           = S_LINK1;
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_front           = (t_op'(i_operation) == OP_POP_FRONT);
                                o_mem_req.rd_en   = 1'b1;
                                o_mem_req.rd_addr = (t_op'(i_operation) == OP_POP_FRONT) ?
                                                    r_head : r_tail;
                                n_state           = S_POP;
                            end
                        end
                        OP_INSERT: begin
                            priority if (pos_neg) begin
                                n_status = ST_INVALID;
                            end else if (pos_gt) begin
                                n_status = ST_OOB;
                            end else if (full) begin
                                n_status = ST_FULL;
                            end else if (pos_zero || pos_end) begin
                                n_kind            = pos_zero ? INS_FRONT : INS_BACK;
                                o_mem_req.rd_en   = 1'b1;
                                o_mem_req.rd_addr = r_free;
                                n_state           = S_LINK1;
                            end else begin
                                n_kind            = INS_MID;
                                n_cur             = r_head;
                                n_left            = COUNT_W'(8'(i_position[5:0]) - 8'd1);
                                o_mem_req.rd_en   = 1'b1;
                                o_mem_req.rd_addr = r_head;
                                n_state           = S_WALK;
                            end
                        end
                        OP_DUMP: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_left            = r_count;
                                o_mem_req.rd_en   = 1'b1;
                                o_mem_req.rd_addr = r_head;
                                n_state           = S_DUMP;
                            end
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                end
            end

            S_REPLY: begin
                if (i_out_free) begin
                    o_emit.valid  = 1'b1;
                    o_emit.status = r_status;
                    o_emit.data   = '0;
                    o_emit.length = 6'(r_count);
                    o_emit.last   = 1'b1;
                    n_state       = S_IDLE;
                end
            end

            S_WALK: begin
                o_mem_req.rd_en = 1'b1;
                if (r_left == '0) begin
                    n_nx              = i_mem_rsp.next;
                    o_mem_req.rd_addr = r_free;
                    n_state           = S_LINK1;
                end else begin
                    n_cur             = i_mem_rsp.next;
                    o_mem_req.rd_addr = i_mem_rsp.next;
                    n_left            = r_left - 1'b1;
                end
            end

            S_LINK1: begin
                // take the free head, store value and the node's known links
                n_new             = r_free;
                n_free            = i_mem_rsp.next;
                o_mem_req.wr_addr = r_free;
                o_mem_req.we_val  = 1'b1;
                o_mem_req.wr_val  = r_value;
                o_mem_req.wr_next = (r_kind == INS_MID) ? r_nx : r_head;
                o_mem_req.wr_prev = (r_kind == INS_MID) ? r_cur : r_tail;
                o_mem_req.we_next = (r_kind != INS_BACK);
                o_mem_req.we_prev = (r_kind != INS_FRONT);
                n_state           = (r_kind == INS_MID) ? S_LINK3 : S_LINK2;
            end

            S_LINK3: begin
                o_mem_req.wr_addr = r_nx;
                o_mem_req.we_prev = 1'b1;
                o_mem_req.wr_prev = r_new;
                n_state           = S_LINK2;
            end

            S_LINK2: begin
                if (i_out_free) begin
                    unique case (r_kind)
                        INS_BACK: begin
                            o_mem_req.wr_addr = r_tail;
                            o_mem_req.we_next = (r_count != '0);
                            o_mem_req.wr_next = r_new;
                            n_tail            = r_new;
                            if (r_count == '0) begin
                                n_head = r_new;
                            end
                        end
                        INS_FRONT: begin
                            o_mem_req.wr_addr = r_head;
                            o_mem_req.we_prev = (r_count != '0);
                            o_mem_req.wr_prev = r_new;
                            n_head            = r_new;
                            if (r_count == '0) begin
                                n_tail = r_new;
                            end
                        end
                        default: begin
                            o_mem_req.wr_addr = r_cur;
                            o_mem_req.we_next = 1'b1;
                            o_mem_req.wr_next = r_new;
                        end
                    endcase
                    n_count       = r_count + 1'b1;
                    o_emit.valid  = 1'b1;
                    o_emit.status = ST_OK;
                    o_emit.data   = '0;
                    o_emit.length = 6'(n_count);
                    o_emit.last   = 1'b1;
                    n_state       = S_IDLE;
                end
            end

            S_POP: begin
                if (i_out_free) begin
                    // return the node to the free chain
                    o_mem_req.wr_addr = pop_slot;
                    o_mem_req.we_next = 1'b1;
                    o_mem_req.wr_next = r_free;
                    n_free            = pop_slot;
                    if (r_front) begin
                        n_head = i_mem_rsp.next;
                    end else begin
                        n_tail = i_mem_rsp.prev;
                    end
                    n_count       = r_count - 1'b1;
                    o_emit.valid  = 1'b1;
                    o_emit.status = ST_OK;
                    o_emit.data   = from_store(i_mem_rsp.value);
                    o_emit.length = 6'(n_count);
                    o_emit.last   = 1'b1;
                    n_state       = S_IDLE;
                end
            end

            S_DUMP: begin
                if (i_out_free) begin
                    o_emit.valid  = 1'b1;
                    o_emit.status = ST_OK;
                    o_emit.data   = from_store(i_mem_rsp.value);
                    o_emit.length = 6'(r_count);
                    o_emit.last   = (r_left == COUNT_W'(1));
                    if (r_left == COUNT_W'(1)) begin
                        n_state = S_IDLE;
                    end else begin
                        o_mem_req.rd_en   = 1'b1;
                        o_mem_req.rd_addr = i_mem_rsp.next;
                        n_left            = r_left - 1'b1;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_free  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_free  <= n_free;
            r_count <= n_count;
        end
        r_kind   <= n_kind;
        r_front  <= n_front;
        r_status <= n_status;
        r_value  <= n_value;
        r_cur    <= n_cur;
        r_nx     <= n_nx;
        r_new    <= n_new;
        r_left   <= n_left;
    end

`ifndef SYNTHESIS
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(CAPACITY))
        else $error("element count above capacity");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit.valid |-> i_out_free)
        else $error("result issued into an occupied output register");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> (r_state != S_IDLE))
        else $error("accepted request did not start a sequence");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
            (r_count == $past(r_count) + 1'b1 || r_count == $past(r_count) - 1'b1))
        else $error("element count moved by more than one");

    a_pop_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP || r_state == S_DUMP) |-> (r_count != '0))
        else $error("node read on an empty list");
`endif

endmodule

// ===== test/doubly_linked_list_deque_tb.sv =====
// ============================================================================
// doubly_linked_list_deque_tb
// Self-checking bench for the bounded linked-list deque. A queue-based
// predictor mirrors the list contents and queues the expected results of
// every accepted request. A checker process compares each accepted result
// field by field.
// ============================================================================
module doubly_linked_list_deque_tb;

    import dld_pkg::*;

    // Codes 6 and 7 have no operation behind them. The block must still
    // answer them with one plain result.
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    localparam logic [31:0] VAL_MAX       = 32'h7FFF_FFFF;
    localparam logic [31:0] VAL_MIN       = 32'h8000_0000;
    localparam logic [6:0]  POS_MINUS_ONE = 7'h7F;
    localparam logic [6:0]  POS_MOST_NEG  = 7'h40;
    localparam logic [6:0]  POS_TOP       = 7'd63;

    localparam int STALL_LIMIT   = 4000;  // cycles with no handshake at all
    localparam int DRAIN_SLACK   = 40;    // extra wait for stray results after a drain
    localparam int LONG_HOLD     = 300;   // receiver hold-off while the list fills
    localparam int RANDOM_ITEMS  = 321;

    typedef struct {
        logic [2:0]  status;
        logic [31:0] data;
        logic [5:0]  length;
        logic        last;
    } t_deque_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [2:0]         i_operation;
    logic signed [31:0] i_value;
    logic signed [6:0]  i_position;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [2:0]         o_status;
    logic signed [31:0] o_data_out;
    logic [5:0]         o_length;
    logic               o_last;

    // Predictor state: the list contents, head first.
    logic [31:0]   deque_contents[$];
    t_deque_result pending_results[$];

    bit idle_enable;       // random gaps on both sides
    bit filling;           // random phase is currently growing the list
    int sink_hold_cycles;  // set by a test to make the receiver hold off

    int error_count;
    int n_requests;
    int n_results;
    int n_full;
    int n_dump_items;
    int peak_length;

    doubly_linked_list_deque dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_operation),
        .i_value     (i_value),
        .i_position  (i_position),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_status    (o_status),
        .o_data_out  (o_data_out),
        .o_length    (o_length),
        .o_last      (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Queue one expected result; length is taken after the list has changed.
    function automatic void queue_result(input logic [2:0] status, input logic [31:0] data,
                                         input logic last);
        t_deque_result r;
        r.status = status;
        r.data   = data;
        r.length = 6'(deque_contents.size());
        r.last   = last;
        pending_results.insert(pending_results.size(), r);
    endfunction

    // Apply one accepted request to the mirrored list and queue its results.
    function automatic void predict_deque_op(input logic [2:0] op, input logic [31:0] val,
                                             input logic [6:0] pos);
        int          len;
        int          idx;
        logic [31:0] popped;
        len = deque_contents.size();
        case (op)
            OP_PUSH_BACK, OP_PUSH_FRONT: begin
                if (len >= CAPACITY) begin
                    n_full++;
                    queue_result(ST_FULL, '0, 1'b1);
                end else begin
                    if (op == OP_PUSH_BACK) begin
                        deque_contents.insert(len, val);
                    end else begin
                        deque_contents.insert(0, val);
                    end
                    queue_result(ST_OK, '0, 1'b1);
                end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
                if (len == 0) begin
                    queue_result(ST_EMPTY, '0, 1'b1);
                end else begin
                    if (op == OP_POP_FRONT) begin
                        popped = deque_contents[0];
                        deque_contents.delete(0);
                    end else begin
                        popped = deque_contents[len - 1];
                        deque_contents.delete(len - 1);
                    end
                    queue_result(ST_OK, popped, 1'b1);
                end
            end
            OP_INSERT: begin
                // Checks apply in order: sign, then range, then pool space.
                if (pos[6]) begin
                    queue_result(ST_INVALID, '0, 1'b1);
                end else if (int'(pos[5:0]) > len) begin
                    queue_result(ST_OOB, '0, 1'b1);
                end else if (len >= CAPACITY) begin
                    n_full++;
                    queue_result(ST_FULL, '0, 1'b1);
                end else begin
                    deque_contents.insert(int'(pos[5:0]), val);
                    queue_result(ST_OK, '0, 1'b1);
                end
            end
            OP_DUMP: begin
                if (len == 0) begin
                    queue_result(ST_EMPTY, '0, 1'b1);
                end else begin
                    for (idx = 0; idx < len; idx++) begin
                        queue_result(ST_OK, deque_contents[idx], 1'(idx == len - 1));
                    end
                    n_dump_items += len;
                end
            end
            default: begin
                queue_result(ST_OK, '0, 1'b1);
            end
        endcase
        if (deque_contents.size() > peak_length) begin
            peak_length = deque_contents.size();
        end
    endfunction

    // ------------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------------

    // Mostly back to back, often a short gap, now and then a long gap.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Mostly legal positions, with a share past the end and some negative.
    function automatic logic [6:0] pick_position(input int len);
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) begin
            return 7'($urandom_range(64, 127));
        end else if (r < 24) begin
            return 7'($urandom_range(len + 1, 63));
        end
        return 7'($urandom_range(0, len));
    endfunction

    function automatic logic [2:0] pick_op(input int push_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) begin
            return ($urandom_range(0, 1) != 0) ? OP_SPARE_6 : OP_SPARE_7;
        end else if (r < 9) begin
            return OP_DUMP;
        end
        if ($urandom_range(0, 99) < push_pct) begin
            case ($urandom_range(0, 3))
                0:       return OP_PUSH_BACK;
                1:       return OP_PUSH_FRONT;
                default: return OP_INSERT;
            endcase
        end
        return ($urandom_range(0, 1) != 0) ? OP_POP_FRONT : OP_POP_BACK;
    endfunction

    // ------------------------------------------------------------------------
    // Request driver and pauses
    // ------------------------------------------------------------------------

    // Offer one request and hold it until the block takes it. Valid is only
    // lowered when a gap follows, so back-to-back requests keep it high.
    task automatic send_request(input logic [2:0] op, input logic [31:0] val,
                                input logic [6:0] pos);
        int gap;
        gap = idle_enable ? pick_gap() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_value     <= val;
        i_position  <= pos;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_deque_op(op, val, pos);
        n_requests++;
    endtask

    // Stop offering and wait until every expected result has been taken,
    // then wait out DRAIN_SLACK so that any stray result can still show.
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
        repeat (DRAIN_SLACK) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Short directed list: empty cases, bad positions, both ends, middle
    // inserts, field extremes and the two unused codes.
    task automatic test_directed();
        idle_enable = 1'b0;
        send_request(OP_DUMP,       '0,           '0);             // dump on empty
        send_request(OP_POP_FRONT,  '0,           '0);             // pop on empty
        send_request(OP_POP_BACK,   VAL_MAX,      POS_TOP);        // pop on empty
        send_request(OP_INSERT,     32'h1,        POS_MINUS_ONE);  // negative position
        send_request(OP_INSERT,     32'h2,        POS_MOST_NEG);   // most negative
        send_request(OP_INSERT,     32'h3,        7'd1);           // past end of empty
        send_request(OP_INSERT,     32'h4,        POS_TOP);        // far past end
        send_request(OP_INSERT,     VAL_MAX,      7'd0);           // insert at head
        send_request(OP_PUSH_BACK,  VAL_MIN,      '0);
        send_request(OP_PUSH_FRONT, '0,           '0);
        send_request(OP_INSERT,     '1,           7'd3);           // insert at length
        send_request(OP_INSERT,     32'h5A5A_A5A5, 7'd2);          // middle
        send_request(OP_INSERT,     32'h1234_5678, 7'd1);          // just after head
        send_request(OP_INSERT,     32'hA5A5_5A5A, 7'd5);          // just before tail
        send_request(OP_DUMP,       '0,           '0);
        send_request(OP_SPARE_6,    VAL_MAX,      POS_MINUS_ONE);
        send_request(OP_SPARE_7,    VAL_MIN,      POS_TOP);
        send_request(OP_POP_FRONT,  '0,           '0);
        send_request(OP_POP_BACK,   '0,           '0);
        send_request(OP_INSERT,     32'h6,        7'd6);           // one past length
        send_request(OP_DUMP,       '0,           '0);
        wait_for_drain();
    endtask

    // Fill the pool while the receiver holds off, so the output side backs up
    // and the block stalls its input. Then probe every refusal on a full pool.
    task automatic test_fill_to_capacity();
        int k;
        idle_enable      = 1'b0;
        sink_hold_cycles = LONG_HOLD;
        k = 0;
        while (deque_contents.size() < CAPACITY) begin
            case (k % 3)
                0:       send_request(OP_PUSH_BACK, pick_value(), '0);
                1:       send_request(OP_PUSH_FRONT, pick_value(), '0);
                default: send_request(OP_INSERT, pick_value(),
                                      7'($urandom_range(1, deque_contents.size())));
            endcase
            k++;
        end
        send_request(OP_PUSH_BACK,  32'h77,       '0);             // full
        send_request(OP_PUSH_FRONT, 32'h78,       '0);             // full
        send_request(OP_INSERT,     32'h79,       POS_MINUS_ONE);  // sign wins over full
        send_request(OP_INSERT,     32'h7A,       7'd33);          // range wins over full
        send_request(OP_INSERT,     32'h7B,       7'd10);          // full
        send_request(OP_INSERT,     32'h7C,       7'd32);          // full at length
        send_request(OP_DUMP,       '0,           '0);             // longest dump
        // Pause the sender until the whole dump has been taken.
        wait_for_drain();
        idle_enable = 1'b1;
        while (deque_contents.size() > 0) begin
            send_request(($urandom_range(0, 1) != 0) ? OP_POP_FRONT : OP_POP_BACK,
                         pick_value(), 7'($urandom));
        end
        send_request(OP_POP_BACK, '0, '0);
        wait_for_drain();
    endtask

    // Random requests whose mix swings between growing and shrinking the
    // list, so both empty and full are reached again and again.
    task automatic test_random_mix(input int count, input bit with_idle);
        int          k;
        int          len;
        logic [2:0]  op;
        logic [6:0]  pos;
        idle_enable = with_idle;
        for (k = 0; k < count; k++) begin
            len = deque_contents.size();
            if (len >= CAPACITY && $urandom_range(0, 3) == 0) begin
                filling = 1'b0;
            end else if (len == 0 && $urandom_range(0, 1) == 0) begin
                filling = 1'b1;
            end
            op  = pick_op(filling ? 80 : 20);
            pos = (op == OP_INSERT) ? pick_position(len) : 7'($urandom);
            send_request(op, pick_value(), pos);
        end
        wait_for_drain();
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------------
    initial begin : receiver
        int n;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (sink_hold_cycles > 0) begin
                n = sink_hold_cycles;
                sink_hold_cycles = 0;
                i_out_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end else if (idle_enable && $urandom_range(0, 3) == 0) begin
                n = pick_gap();
                i_out_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Checker: compare each accepted result with the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_deque_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_results++;
            if (pending_results.size() == 0) begin
                error_count++;
                $error("unexpected result: status %0d data %h length %0d last %0d",
                       o_status, o_data_out, o_length, o_last);
            end else begin
                want = pending_results[0];
                pending_results.delete(0);
                if (o_status !== want.status) begin
                    error_count++;
                    $error("status mismatch: expected %0d, actual %0d", want.status, o_status);
                end
                if (o_data_out !== want.data) begin
                    error_count++;
                    $error("data_out mismatch: expected %h, actual %h", want.data, o_data_out);
                end
                if (o_length !== want.length) begin
                    error_count++;
                    $error("length mismatch: expected %0d, actual %0d", want.length, o_length);
                end
                if (o_last !== want.last) begin
                    error_count++;
                    $error("last mismatch: expected %0d, actual %0d", want.last, o_last);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run if no handshake happens for too long
    // ------------------------------------------------------------------------
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("Timeout: no handshake for %0d cycles, %0d results still due",
                 STALL_LIMIT, pending_results.size());
        $display("FAILED: results differ");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        idle_enable      = 1'b0;
        filling          = 1'b1;
        sink_hold_cycles = 0;
        error_count      = 0;
        n_requests       = 0;
        n_results        = 0;
        n_full           = 0;
        n_dump_items     = 0;
        peak_length      = 0;

        // Drive every input to a known value before the first edge.
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_operation <= OP_PUSH_BACK;
        i_value     <= '0;
        i_position  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        test_directed();
        test_fill_to_capacity();
        test_random_mix(RANDOM_ITEMS / 3, 1'b1);
        test_random_mix(RANDOM_ITEMS / 3, 1'b0);   // no gaps on either side
        test_random_mix(RANDOM_ITEMS / 3, 1'b1);

        $display("Covered %0d requests and %0d results, %0d of them dump elements.",
                 n_requests, n_results, n_dump_items);
        $display("List reached length %0d; %0d requests refused on a full pool.",
                 peak_length, n_full);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
